@@ src/assert_macros.svh @@
// Assertion macros shared by the RTL of the gate controller.
// Included by bare file name; needs no other file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Property checked at every clock edge outside reset.
`define ASSERT_CLK(name, clock, reset, prop, msg) \
  name: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Implication from one cycle to the next, outside reset.
`define ASSERT_NEXT(name, clock, reset, cause, effect, msg) \
  name: assert property (@(posedge clock) disable iff (reset) (cause) |=> (effect)) \
    else $error(msg);

`else

`define ASSERT_CLK(name, clock, reset, prop, msg)
`define ASSERT_NEXT(name, clock, reset, cause, effect, msg)

`endif

`endif

@@ src/gate_ctrl_pkg.sv @@
// Package for the gate controller: field widths, register indexes, codes,
// reset values and small helper functions. Depends on nothing.
`timescale 1ns / 1ps

package gate_ctrl_pkg;

  // Field widths.
  localparam int PULSE_W   = 15;
  localparam int PHASE_W   = 3;
  localparam int MODE_W    = 2;
  localparam int ECHO_W    = 16;
  localparam int STEP_W    = 8;
  localparam int ELAPSED_W = 8;
  localparam int HOLD_W    = 16;
  localparam int COUNT_W   = 4;
  localparam int ADDR_W    = 3;
  localparam int CFG_W     = 16;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 24;

  // Configuration register indexes.
  localparam logic [ADDR_W-1:0] REG_CLOSED_PULSE   = 3'd0;
  localparam logic [ADDR_W-1:0] REG_OPEN_PULSE     = 3'd1;
  localparam logic [ADDR_W-1:0] REG_RAMP_STEP      = 3'd2;
  localparam logic [ADDR_W-1:0] REG_RAMP_INTERVAL  = 3'd3;
  localparam logic [ADDR_W-1:0] REG_OPEN_HOLD_MS   = 3'd4;
  localparam logic [ADDR_W-1:0] REG_TRIGGER_PERIOD = 3'd5;
  localparam logic [ADDR_W-1:0] REG_NEAR_ECHO_US   = 3'd6;
  localparam logic [ADDR_W-1:0] REG_HITS_NEEDED    = 3'd7;

  // Reset values of the configuration registers.
  localparam logic [PULSE_W-1:0]   RST_CLOSED_PULSE   = 15'd1000;
  localparam logic [PULSE_W-1:0]   RST_OPEN_PULSE     = 15'd1800;
  localparam logic [STEP_W-1:0]    RST_RAMP_STEP      = 8'd5;
  localparam logic [ELAPSED_W-1:0] RST_RAMP_INTERVAL  = 8'd20;
  localparam logic [HOLD_W-1:0]    RST_OPEN_HOLD_MS   = 16'd20000;
  localparam logic [ELAPSED_W-1:0] RST_TRIGGER_PERIOD = 8'd50;
  localparam logic [ECHO_W-1:0]    RST_NEAR_ECHO_US   = 16'd2000;
  localparam logic [COUNT_W-1:0]   RST_HITS_NEEDED    = 4'd3;

  // Input item kinds.
  localparam logic [MODE_W-1:0] MODE_TICK    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_COMMAND = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LEFT    = 2'd2;
  localparam logic [MODE_W-1:0] MODE_RIGHT   = 2'd3;

  // Gate phase codes.
  localparam logic [PHASE_W-1:0] PH_CLOSED   = 3'd0;
  localparam logic [PHASE_W-1:0] PH_OPENING  = 3'd1;
  localparam logic [PHASE_W-1:0] PH_OPEN     = 3'd2;
  localparam logic [PHASE_W-1:0] PH_CLOSING  = 3'd3;
  localparam logic [PHASE_W-1:0] PH_STOPPED  = 3'd4;
  localparam logic [PHASE_W-1:0] PH_OBSTACLE = 3'd5;

  // Right echoes at or below this are sensor ringing and are dropped.
  localparam logic [ECHO_W-1:0]    SHORT_RIGHT_ECHO = 16'd100;
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX      = 8'hFF;
  localparam logic [COUNT_W-1:0]   COUNT_MAX        = 4'hF;

  // The sensors are fired and their echoes used only in these phases.
  function automatic logic is_sensing(input logic [PHASE_W-1:0] phase);
    return (phase == PH_OPENING) || (phase == PH_CLOSING) || (phase == PH_OBSTACLE);
  endfunction

  function automatic logic [ELAPSED_W-1:0] sat_inc_elapsed(input logic [ELAPSED_W-1:0] v);
    return (v == ELAPSED_MAX) ? v : v + 8'd1;
  endfunction

  function automatic logic [COUNT_W-1:0] sat_inc_count(input logic [COUNT_W-1:0] v);
    return (v == COUNT_MAX) ? v : v + 4'd1;
  endfunction

endpackage

@@ src/gate_controller_with_obstacle_stop_core.sv @@
// Top level of the gate controller with obstacle stop.
// Depends on gate_ctrl_pkg and on assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// The block runs a six-phase gate machine (closed, opening, open, closing,
// stopped, obstacle) from a stream of items: millisecond ticks, remote
// commands, and left or right ultrasonic echo times, selected by s_tuser.
// Every accepted item yields exactly one result transfer carrying the servo
// pulse width, the phase, the obstacle flag and the two sensor trigger strobes
// as they stand after that item. A command only arms a pending flag that the
// next tick acts on. The block takes one item per clock cycle unless stalled:
// the whole update is one pass of compare and small add logic from the state
// registers into the result register, and each result appears in the cycle
// after its item. The result register decouples the sides, so a new item is
// accepted whenever it is empty or being drained in the same cycle. There is
// no clearing pass after reset. The user writes configuration registers via
// cfg_we, cfg_addr and cfg_data while the stream is idle; it is not enforced.
module gate_controller_with_obstacle_stop_core (
  input  logic                                 clk,
  input  logic                                 rst,
  // Input stream.
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [gate_ctrl_pkg::IN_DATA_W-1:0]  s_tdata,   // [15:0] echo_time
  input  logic [gate_ctrl_pkg::MODE_W-1:0]     s_tuser,   // [1:0] mode
  // Result stream.
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // [14:0] pulse_width, [17:15] gate_state, [18] obstacle, [19] trigger_a,
  // [20] trigger_b, [23:21] zero
  output logic [gate_ctrl_pkg::OUT_DATA_W-1:0] m_tdata,
  // Configuration write port.
  input  logic                                 cfg_we,
  input  logic [gate_ctrl_pkg::ADDR_W-1:0]     cfg_addr,
  input  logic [gate_ctrl_pkg::CFG_W-1:0]      cfg_data
);

  import gate_ctrl_pkg::*;

  // Configuration registers.
  logic [PULSE_W-1:0]   closed_pulse;
  logic [PULSE_W-1:0]   open_pulse;
  logic [STEP_W-1:0]    ramp_step;
  logic [ELAPSED_W-1:0] ramp_interval;
  logic [HOLD_W-1:0]    open_hold_ms;
  logic [ELAPSED_W-1:0] trigger_period;
  logic [ECHO_W-1:0]    near_echo_us;
  logic [COUNT_W-1:0]   hits_needed;

  // Gate state.
  logic [PHASE_W-1:0]   gate_phase, gate_phase_next;
  logic                 was_closing, was_closing_next;
  logic                 command_pending, command_pending_next;
  logic [PULSE_W-1:0]   servo_pulse, servo_pulse_next;
  logic [ELAPSED_W-1:0] ramp_elapsed, ramp_elapsed_next;
  logic [HOLD_W-1:0]    hold_count, hold_count_next;
  logic                 hold_running, hold_running_next;
  logic [ELAPSED_W-1:0] trigger_elapsed, trigger_elapsed_next;
  logic                 next_is_a, next_is_a_next;
  logic [COUNT_W-1:0]   near_count_left, near_count_left_next;
  logic [COUNT_W-1:0]   near_count_right, near_count_right_next;
  logic                 blocked_left, blocked_left_next;
  logic                 blocked_right, blocked_right_next;

  // Per-item working values.
  logic                  accept;
  logic [MODE_W-1:0]     mode;
  logic [ECHO_W-1:0]     echo_time;
  logic                  fire_a, fire_b;
  logic                  blocked;
  logic [PULSE_W-1:0]    target;
  logic [HOLD_W:0]       hold_sum;
  logic [PULSE_W:0]      up_sum;
  logic [PULSE_W-1:0]    down_diff;
  logic                  near;
  logic [OUT_DATA_W-1:0] result_next;

  assign mode      = s_tuser;
  assign echo_time = s_tdata;
  assign s_tready  = !m_tvalid || m_tready;
  assign accept    = s_tvalid && s_tready;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      closed_pulse   <= RST_CLOSED_PULSE;
      open_pulse     <= RST_OPEN_PULSE;
      ramp_step      <= RST_RAMP_STEP;
      ramp_interval  <= RST_RAMP_INTERVAL;
      open_hold_ms   <= RST_OPEN_HOLD_MS;
      trigger_period <= RST_TRIGGER_PERIOD;
      near_echo_us   <= RST_NEAR_ECHO_US;
      hits_needed    <= RST_HITS_NEEDED;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_CLOSED_PULSE:   closed_pulse   <= cfg_data[PULSE_W-1:0];
        REG_OPEN_PULSE:     open_pulse     <= cfg_data[PULSE_W-1:0];
        REG_RAMP_STEP:      ramp_step      <= cfg_data[STEP_W-1:0];
        REG_RAMP_INTERVAL:  ramp_interval  <= cfg_data[ELAPSED_W-1:0];
        REG_OPEN_HOLD_MS:   open_hold_ms   <= cfg_data[HOLD_W-1:0];
        REG_TRIGGER_PERIOD: trigger_period <= cfg_data[ELAPSED_W-1:0];
        REG_NEAR_ECHO_US:   near_echo_us   <= cfg_data[ECHO_W-1:0];
        REG_HITS_NEEDED:    hits_needed    <= cfg_data[COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Next-state logic for one item. The steps of a tick run in a fixed order:
  // timers count, the open-hold timer may start closing, a sensor may fire,
  // the phase machine runs, and then at most one ramp step is taken.
  always_comb begin
    gate_phase_next       = gate_phase;
    was_closing_next      = was_closing;
    command_pending_next  = command_pending;
    servo_pulse_next      = servo_pulse;
    ramp_elapsed_next     = ramp_elapsed;
    hold_count_next       = hold_count;
    hold_running_next     = hold_running;
    trigger_elapsed_next  = trigger_elapsed;
    next_is_a_next        = next_is_a;
    near_count_left_next  = near_count_left;
    near_count_right_next = near_count_right;
    blocked_left_next     = blocked_left;
    blocked_right_next    = blocked_right;
    fire_a    = 1'b0;
    fire_b    = 1'b0;
    blocked   = blocked_left || blocked_right;
    target    = closed_pulse;
    hold_sum  = {1'b0, hold_count} + 17'd1;
    up_sum    = {1'b0, servo_pulse} + {8'd0, ramp_step};
    down_diff = servo_pulse - target;
    near      = (echo_time <= near_echo_us);

    case (mode)
      MODE_TICK: begin
        ramp_elapsed_next    = sat_inc_elapsed(ramp_elapsed);
        trigger_elapsed_next = sat_inc_elapsed(trigger_elapsed);

        if (hold_running) begin
          if (hold_sum >= {1'b0, open_hold_ms}) begin
            hold_running_next = 1'b0;
            hold_count_next   = '0;
            if (gate_phase == PH_OPEN) begin
              gate_phase_next = PH_CLOSING;
            end
          end else begin
            hold_count_next = hold_sum[HOLD_W-1:0];
          end
        end

        // Alternate the two sensors, starting with the second one.
        if (is_sensing(gate_phase_next) && (trigger_elapsed_next >= trigger_period)) begin
          trigger_elapsed_next = '0;
          fire_a         = next_is_a;
          fire_b         = !next_is_a;
          next_is_a_next = !next_is_a;
        end

        // Phase machine, working on the phase left by the hold timer.
        case (gate_phase_next)
          PH_OPENING: begin
            target = open_pulse;
            if (blocked) begin
              gate_phase_next = PH_OBSTACLE;
            end else if (servo_pulse == open_pulse) begin
              gate_phase_next   = PH_OPEN;
              hold_count_next   = '0;
              hold_running_next = 1'b1;
            end else if (command_pending) begin
              was_closing_next     = 1'b0;
              gate_phase_next      = PH_STOPPED;
              command_pending_next = 1'b0;
            end
          end
          PH_OPEN: begin
            target = open_pulse;
            if (command_pending) begin
              gate_phase_next      = PH_CLOSING;
              command_pending_next = 1'b0;
              hold_count_next      = '0;
              hold_running_next    = 1'b0;
            end
          end
          PH_CLOSING: begin
            target = closed_pulse;
            if (blocked) begin
              gate_phase_next = PH_OBSTACLE;
            end else if (servo_pulse == closed_pulse) begin
              gate_phase_next = PH_CLOSED;
            end else if (command_pending) begin
              was_closing_next     = 1'b1;
              gate_phase_next      = PH_STOPPED;
              command_pending_next = 1'b0;
            end
          end
          PH_STOPPED: begin
            // A stopped gate holds where it is and resumes the other way.
            target = servo_pulse;
            if (command_pending) begin
              gate_phase_next      = was_closing ? PH_OPENING : PH_CLOSING;
              command_pending_next = 1'b0;
            end
          end
          PH_OBSTACLE: begin
            // Leaving the obstacle phase always reopens the gate.
            target = servo_pulse;
            if (!blocked && command_pending) begin
              gate_phase_next      = PH_OPENING;
              command_pending_next = 1'b0;
            end
          end
          default: begin
            // Closed, and the unused codes that behave as closed.
            gate_phase_next = PH_CLOSED;
            target          = closed_pulse;
            if (command_pending) begin
              gate_phase_next      = PH_OPENING;
              command_pending_next = 1'b0;
            end
          end
        endcase

        // One ramp step toward the target, clamped so it never overshoots.
        down_diff = servo_pulse - target;
        if ((servo_pulse != target) && (ramp_elapsed_next > ramp_interval)) begin
          if (servo_pulse < target) begin
            servo_pulse_next = (up_sum > {1'b0, target}) ? target : up_sum[PULSE_W-1:0];
          end else begin
            servo_pulse_next = (down_diff < {7'd0, ramp_step}) ? target
                               : servo_pulse - {7'd0, ramp_step};
          end
          ramp_elapsed_next = '0;
        end
      end
      MODE_COMMAND: begin
        command_pending_next = 1'b1;
      end
      MODE_LEFT: begin
        if (is_sensing(gate_phase)) begin
          near_count_left_next = near ? sat_inc_count(near_count_left) : '0;
          blocked_left_next    = (near_count_left_next >= hits_needed);
        end
      end
      MODE_RIGHT: begin
        if (is_sensing(gate_phase) && (echo_time > SHORT_RIGHT_ECHO)) begin
          near_count_right_next = near ? sat_inc_count(near_count_right) : '0;
          blocked_right_next    = (near_count_right_next >= hits_needed);
        end
      end
      default: begin
      end
    endcase

    result_next = {3'b000, fire_b, fire_a, blocked_left_next || blocked_right_next,
                   gate_phase_next, servo_pulse_next};
  end

  // State registers advance only when an item is accepted.
  always_ff @(posedge clk) begin
    if (rst) begin
      gate_phase       <= PH_CLOSED;
      was_closing      <= 1'b0;
      command_pending  <= 1'b0;
      servo_pulse      <= RST_CLOSED_PULSE;
      ramp_elapsed     <= '0;
      hold_count       <= '0;
      hold_running     <= 1'b0;
      trigger_elapsed  <= ELAPSED_MAX;
      next_is_a        <= 1'b0;
      near_count_left  <= '0;
      near_count_right <= '0;
      blocked_left     <= 1'b0;
      blocked_right    <= 1'b0;
    end else if (accept) begin
      gate_phase       <= gate_phase_next;
      was_closing      <= was_closing_next;
      command_pending  <= command_pending_next;
      servo_pulse      <= servo_pulse_next;
      ramp_elapsed     <= ramp_elapsed_next;
      hold_count       <= hold_count_next;
      hold_running     <= hold_running_next;
      trigger_elapsed  <= trigger_elapsed_next;
      next_is_a        <= next_is_a_next;
      near_count_left  <= near_count_left_next;
      near_count_right <= near_count_right_next;
      blocked_left     <= blocked_left_next;
      blocked_right    <= blocked_right_next;
    end
  end

  // Result register: filled on acceptance, emptied when the transfer completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= result_next;
    end
  end

  // Only one sensor is ever fired by a single tick.
  `ASSERT_CLK(a_one_trigger, clk, rst, !(m_tvalid && m_tdata[19] && m_tdata[20]), "both sensors fired on one tick")
  // Commands and echoes never fire a sensor.
  `ASSERT_NEXT(a_trigger_on_tick, clk, rst, accept && (s_tuser != MODE_TICK), !(m_tdata[19] || m_tdata[20]), "sensor fired on a non-tick item")
  // The auto-close timer runs only while the gate stands open.
  `ASSERT_CLK(a_hold_when_open, clk, rst, !hold_running || (gate_phase == PH_OPEN), "hold timer running outside the open phase")
  // The servo pulse changes only as a result of an accepted item.
  `ASSERT_NEXT(a_pulse_holds, clk, rst, !accept, $stable(servo_pulse), "servo pulse moved without an item")

endmodule
